@@ src/i420tl_pkg.sv @@
// Shared types and constants for the I420 tile/linear address map.
// No dependencies; imported by every module of the block.
package i420tl_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int TILE_BYTES   = 4096;
  localparam int TILE_COLS    = 256;
  localparam int TILE_ROWS    = 16;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;
  localparam int OFF_W   = 25;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } frame_cfg_t;

endpackage

@@ src/i420tl_pipe.sv @@
// Three-stage address pipeline: plane decode and products, partial sums,
// base add and output register. Depends on i420tl_pkg.
module i420tl_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  i420tl_pkg::frame_cfg_t       cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_plane,
  input  logic [i420tl_pkg::COORD_W-1:0] in_col,
  input  logic [i420tl_pkg::COORD_W-1:0] in_row,
  input  logic [i420tl_pkg::PIX_W-1:0] in_pix,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [i420tl_pkg::OFF_W-1:0] out_lin,
  output logic [i420tl_pkg::OFF_W-1:0] out_til,
  output logic [i420tl_pkg::PIX_W-1:0] out_pix,
  output i420tl_pkg::status_t          out_status
);
  import i420tl_pkg::*;

  logic rdy1, rdy2, rdy3;
  logic v1_r, v2_r, v3_r;

  // stage 1 payload
  status_t            st1_r;
  logic [OFF_W-1:0]   base1_r, linmul1_r;
  logic [COORD_W-1:0] col1_r;
  logic [12:0]        tmul1_r;
  logic [3:0]         tx1_r;
  logic [11:0]        intile1_r;
  logic [PIX_W-1:0]   pix1_r;

  // stage 2 payload
  status_t            st2_r;
  logic [OFF_W-1:0]   base2_r, linp2_r, tilp2_r;
  logic [PIX_W-1:0]   pix2_r;

  // stage 3 (output)
  status_t            st3_r;
  logic [OFF_W-1:0]   lin3_r, til3_r;
  logic [PIX_W-1:0]   pix3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1 && rst_n;

  // stage 1 logic
  logic [3:0]         wb;
  logic [7:0]         hb;
  logic               size_ok, is_y, plane_ok, in_range;
  logic [DIM_W-1:0]   pw, ph;
  logic [11:0]        wh_units;
  logic [14:0]        wh_v;
  logic [15:0]        row_mul;
  logic [4:0]         tiles_across;
  status_t            st1_nxt;
  logic [OFF_W-1:0]   base1_nxt, linmul1_nxt;
  logic [12:0]        tmul1_nxt;

  always_comb begin
    wb       = cfg.width[12:9];
    hb       = cfg.height[12:5];
    size_ok  = (cfg.width[8:0] == 9'd0) && (cfg.height[4:0] == 5'd0) &&
               ({1'b0, cfg.width} <= (DIM_W+1)'(MAX_WIDTH)) &&
               ({1'b0, cfg.height} <= (DIM_W+1)'(HEIGHT_LIMIT));
    is_y     = (in_plane == PLANE_Y);
    plane_ok = (in_plane == PLANE_Y) || (in_plane == PLANE_U) || (in_plane == PLANE_V);
    pw       = is_y ? cfg.width  : {1'b0, cfg.width[12:1]};
    ph       = is_y ? cfg.height : {1'b0, cfg.height[12:1]};
    in_range = plane_ok && ({1'b0, in_col} < pw) && ({1'b0, in_row} < ph);
    if (!size_ok) begin
      st1_nxt = ST_SIZE;
    end else if (!in_range) begin
      st1_nxt = ST_RANGE;
    end else begin
      st1_nxt = ST_OK;
    end
    wh_units = 12'(wb * hb);
    wh_v     = 15'(wh_units * 15'd5);
    case (in_plane)
      PLANE_U: base1_nxt = OFF_W'({wh_units, 14'd0});
      PLANE_V: base1_nxt = OFF_W'({wh_v, 12'd0});
      default: base1_nxt = '0;
    endcase
    row_mul      = 16'(in_row * wb);
    linmul1_nxt  = is_y ? OFF_W'({row_mul, 9'd0}) : OFF_W'({row_mul, 8'd0});
    tiles_across = is_y ? {wb, 1'b0} : {1'b0, wb};
    tmul1_nxt    = 13'(in_row[11:4] * tiles_across);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1) begin
      st1_r     <= st1_nxt;
      base1_r   <= base1_nxt;
      linmul1_r <= linmul1_nxt;
      col1_r    <= in_col;
      tmul1_r   <= tmul1_nxt;
      tx1_r     <= in_col[11:8];
      intile1_r <= {in_row[3:0], in_col[7:0]};
      pix1_r    <= in_pix;
    end
  end

  // stage 2 logic
  logic [12:0]      tile_idx;
  logic [OFF_W-1:0] linp2_nxt, tilp2_nxt;

  always_comb begin
    tile_idx  = tmul1_r + 13'(tx1_r);
    linp2_nxt = linmul1_r + OFF_W'(col1_r);
    tilp2_nxt = OFF_W'({tile_idx, 12'd0}) + OFF_W'(intile1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2) begin
      st2_r   <= st1_r;
      base2_r <= base1_r;
      linp2_r <= linp2_nxt;
      tilp2_r <= tilp2_nxt;
      pix2_r  <= pix1_r;
    end
  end

  // stage 3 logic
  logic [OFF_W-1:0] lin3_nxt, til3_nxt;

  always_comb begin
    if (st2_r == ST_OK) begin
      lin3_nxt = base2_r + linp2_r;
      til3_nxt = base2_r + tilp2_r;
    end else begin
      lin3_nxt = '0;
      til3_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (rdy3) begin
      st3_r  <= st2_r;
      lin3_r <= lin3_nxt;
      til3_r <= til3_nxt;
      pix3_r <= pix2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_lin    = lin3_r;
  assign out_til    = til3_r;
  assign out_pix    = pix3_r;
  assign out_status = st3_r;

endmodule

@@ src/i420_tile_linear_address_map.sv @@
// Top level of the I420 tile/linear address map: stream ports, frame size
// registers and the address pipeline. Depends on i420tl_pkg, i420tl_pipe.
//
// Each input word carries one byte of an I420 frame with its plane, column
// and row; the output word gives the byte's offset in the linear planar
// buffer and in the 256x16-byte tiled buffer, the byte itself and a status
// (ok, unsupported frame size, coordinate outside plane; offsets are zero
// unless ok). One word is taken every cycle while input is not held off; a
// word passes through the three register stages of the pipeline (decode and
// products, partial sums, base add). Output stalls back up through the
// stages, which fill bubbles before input is held off. The user must write
// frame width and height through the cfg port only while no word is in
// flight; the block itself does not enforce this.
module i420_tile_linear_address_map (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [i420tl_pkg::IN_DATA_W-1:0]  in_tdata,   // column[11:0], row[23:12],
                                                        // pixel_in[31:24]
  input  logic [1:0]  in_tuser,   // plane[1:0]
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [i420tl_pkg::OUT_DATA_W-1:0] out_tdata,  // linear_offset[24:0],
                                                        // tiled_offset[49:25],
                                                        // pixel_out[57:50], zero[63:58]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [i420tl_pkg::DIM_W-1:0]      cfg_data
);
  import i420tl_pkg::*;

  frame_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= DIM_W'(2048);
      cfg_r.height <= DIM_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg_r.width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg_r.height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [OFF_W-1:0] lin, til;
  logic [PIX_W-1:0] pix;
  status_t          status;

  i420tl_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_plane   (in_tuser),
    .in_col     (in_tdata[11:0]),
    .in_row     (in_tdata[23:12]),
    .in_pix     (in_tdata[31:24]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_lin    (lin),
    .out_til    (til),
    .out_pix    (pix),
    .out_status (status)
  );

  assign out_tdata = {{(OUT_DATA_W-2*OFF_W-PIX_W){1'b0}}, pix, til, lin};
  assign out_tuser = status;

endmodule

@@ src/i420tl_checker.sv @@
// Port-level assertions for i420_tile_linear_address_map, bound to the top.
// Depends on i420tl_pkg.
module i420tl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import i420tl_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata[49:0] == 50'd0)
    else $error("offsets not zero on error status");

  a_low_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK) |-> out_tdata[7:0] == out_tdata[32:25])
    else $error("linear and tiled offsets disagree in the column byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3 && out_tdata[63:58] == 6'd0)
    else $error("bad status code or padding");

endmodule

bind i420_tile_linear_address_map i420tl_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for i420_tile_linear_address_map: directed probes, then randomized frame sizes
// and pixel words, each output word checked against typed probe values or a local address predictor.
// Depends on i420tl_pkg and the block's RTL.
module testbench;
  import i420tl_pkg::*;

  localparam logic [1:0] PLANE_NONE   = 2'd3;
  localparam int         N_PROBES     = 25;
  localparam int         N_PHASES     = 15;
  localparam int         PHASE_WORDS  = 95;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         LONG_HOLD    = 80;
  localparam int         HOLD_AT_WORD = 300;

  typedef struct packed {
    logic [OFF_W-1:0] linear;
    logic [OFF_W-1:0] tiled;
    logic [PIX_W-1:0] pixel;
    status_t          status;
  } addr_result_t;

  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [1:0]         plane;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pix;
    logic               typed;
    logic [OFF_W-1:0]   lin;
    logic [OFF_W-1:0]   til;
    status_t            st;
  } probe_t;

  // typed rows carry the expected offsets; the rest go through the predictor
  probe_t probes [N_PROBES] = '{
    '{13'd2048, 13'd1024, PLANE_Y,    12'd0,    12'd0,    8'h00, 1'b1, 25'd0,        25'd0,        ST_OK},
    '{13'd2048, 13'd1024, PLANE_Y,    12'd5,    12'd3,    8'h5a, 1'b1, 25'd6149,     25'd773,      ST_OK},
    '{13'd2048, 13'd1024, PLANE_Y,    12'd256,  12'd0,    8'ha5, 1'b1, 25'd256,      25'd4096,     ST_OK},
    '{13'd2048, 13'd1024, PLANE_Y,    12'd0,    12'd16,   8'h3c, 1'b1, 25'd32768,    25'd32768,    ST_OK},
    '{13'd2048, 13'd1024, PLANE_Y,    12'd2047, 12'd1023, 8'hff, 1'b0, 25'd0,        25'd0,        ST_OK},
    '{13'd2048, 13'd1024, PLANE_Y,    12'd2048, 12'd0,    8'h81, 1'b1, 25'd0,        25'd0,        ST_RANGE},
    '{13'd2048, 13'd1024, PLANE_Y,    12'd0,    12'd1024, 8'h7e, 1'b1, 25'd0,        25'd0,        ST_RANGE},
    '{13'd2048, 13'd1024, PLANE_U,    12'd0,    12'd0,    8'h11, 1'b1, 25'd2097152,  25'd2097152,  ST_OK},
    '{13'd2048, 13'd1024, PLANE_U,    12'd1023, 12'd511,  8'h22, 1'b0, 25'd0,        25'd0,        ST_OK},
    '{13'd2048, 13'd1024, PLANE_U,    12'd1024, 12'd0,    8'h33, 1'b1, 25'd0,        25'd0,        ST_RANGE},
    '{13'd2048, 13'd1024, PLANE_V,    12'd0,    12'd0,    8'h44, 1'b1, 25'd2621440,  25'd2621440,  ST_OK},
    '{13'd2048, 13'd1024, PLANE_V,    12'd700,  12'd300,  8'h55, 1'b0, 25'd0,        25'd0,        ST_OK},
    '{13'd2048, 13'd1024, PLANE_V,    12'd0,    12'd512,  8'h66, 1'b1, 25'd0,        25'd0,        ST_RANGE},
    '{13'd2048, 13'd1024, PLANE_NONE, 12'd0,    12'd0,    8'h77, 1'b1, 25'd0,        25'd0,        ST_RANGE},
    '{13'd4096, 13'd4096, PLANE_Y,    12'd4095, 12'd4095, 8'hff, 1'b1, 25'd16777215, 25'd16777215, ST_OK},
    '{13'd4096, 13'd4096, PLANE_V,    12'd2047, 12'd2047, 8'hc3, 1'b1, 25'd25165823, 25'd25165823, ST_OK},
    '{13'd4096, 13'd4096, PLANE_U,    12'd4095, 12'd4095, 8'h00, 1'b1, 25'd0,        25'd0,        ST_RANGE},
    '{13'd512,  13'd32,   PLANE_U,    12'd255,  12'd15,   8'h99, 1'b1, 25'd20479,    25'd20479,    ST_OK},
    '{13'd512,  13'd32,   PLANE_Y,    12'd300,  12'd20,   8'h12, 1'b0, 25'd0,        25'd0,        ST_OK},
    '{13'd1536, 13'd96,   PLANE_V,    12'd500,  12'd40,   8'h34, 1'b0, 25'd0,        25'd0,        ST_OK},
    '{13'd0,    13'd0,    PLANE_Y,    12'd0,    12'd0,    8'h56, 1'b1, 25'd0,        25'd0,        ST_RANGE},
    '{13'd1000, 13'd64,   PLANE_Y,    12'd0,    12'd0,    8'h78, 1'b1, 25'd0,        25'd0,        ST_SIZE},
    '{13'd4608, 13'd32,   PLANE_Y,    12'd0,    12'd0,    8'h9a, 1'b1, 25'd0,        25'd0,        ST_SIZE},
    '{13'd512,  13'd4128, PLANE_Y,    12'd0,    12'd0,    8'hbc, 1'b1, 25'd0,        25'd0,        ST_SIZE},
    '{13'd8191, 13'd8191, PLANE_Y,    12'd4095, 12'd4095, 8'hde, 1'b1, 25'd0,        25'd0,        ST_SIZE}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // column[11:0], row[23:12], pixel_in[31:24]
  logic [1:0]  in_tuser   = '0;   // plane[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // linear_offset[24:0], tiled_offset[49:25], pixel_out[57:50]
  logic [1:0]  out_tuser;         // status[1:0]
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [12:0] cfg_data   = '0;

  logic [DIM_W-1:0] frame_w = 13'd2048;
  logic [DIM_W-1:0] frame_h = 13'd1024;
  addr_result_t     pending_maps [$];
  int               fail_count     = 0;
  int               mapped_seen    = 0;
  int               size_seen      = 0;
  int               range_seen     = 0;
  int               settings_count = 0;
  int               rx_idle_rate   = 0;

  i420_tile_linear_address_map u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic addr_result_t map_pixel(input logic [1:0] plane,
                                             input logic [COORD_W-1:0] col,
                                             input logic [COORD_W-1:0] row,
                                             input logic [PIX_W-1:0] pix);
    addr_result_t      r;
    longint unsigned   w, h, pw, ph, base, tile, in_tile;
    w = frame_w;
    h = frame_h;
    pw = 0;
    ph = 0;
    base = 0;
    r.linear = '0;
    r.tiled = '0;
    r.pixel = pix;
    r.status = ST_OK;
    if (w % (2 * TILE_COLS) != 0 || h % (2 * TILE_ROWS) != 0 ||
        w > MAX_WIDTH || h > HEIGHT_LIMIT) begin
      r.status = ST_SIZE;
    end else begin
      case (plane)
        PLANE_Y: begin
          pw = w;
          ph = h;
        end
        PLANE_U: begin
          pw = w / 2;
          ph = h / 2;
          base = w * h;
        end
        PLANE_V: begin
          pw = w / 2;
          ph = h / 2;
          base = w * h + (w * h) / 4;
        end
        default: ;
      endcase
      if (col >= pw || row >= ph) begin
        r.status = ST_RANGE;
      end else begin
        tile = (row / TILE_ROWS) * (pw / TILE_COLS) + col / TILE_COLS;
        in_tile = (row % TILE_ROWS) * TILE_COLS + col % TILE_COLS;
        r.linear = OFF_W'(base + row * pw + col);
        r.tiled = OFF_W'(base + tile * TILE_BYTES + in_tile);
      end
    end
    return r;
  endfunction

  task automatic send_word(input logic [1:0] plane, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] pix,
                           input addr_result_t want);
    in_tvalid <= 1'b1;
    in_tdata <= {pix, row, col};
    in_tuser <= plane;
    do @(posedge clk); while (!in_tready);
    pending_maps.push_back(want);
  endtask

  // hold input off until every queued map has come back
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_w = w;
    frame_h = h;
    settings_count++;
  endtask

  always @(posedge clk) begin : check_outputs
    addr_result_t want, got;
    int           hold_left;
    int           rx_burst;
    bit           long_hold_done;
    if (rst_n && out_tvalid && out_tready) begin
      got.linear = out_tdata[OFF_W-1:0];
      got.tiled = out_tdata[2*OFF_W-1:OFF_W];
      got.pixel = out_tdata[2*OFF_W+PIX_W-1:2*OFF_W];
      got.status = status_t'(out_tuser);
      if (pending_maps.size() == 0) begin
        $error("output word with nothing pending");
        fail_count++;
      end else begin
        want = pending_maps.pop_front();
        if (got.linear !== want.linear) begin
          $error("linear_offset: expected %0d, got %0d", want.linear, got.linear);
          fail_count++;
        end
        if (got.tiled !== want.tiled) begin
          $error("tiled_offset: expected %0d, got %0d", want.tiled, got.tiled);
          fail_count++;
        end
        if (got.pixel !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, got.pixel);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        case (want.status)
          ST_OK:   mapped_seen++;
          ST_SIZE: size_seen++;
          default: range_seen++;
        endcase
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!long_hold_done && mapped_seen + size_seen + range_seen >= HOLD_AT_WORD) begin
      // long back-pressure so the pipeline fills and in_tready drops
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (rx_burst != 0) begin
      rx_burst--;
      out_tready <= 1'b0;
    end else if (rx_idle_rate != 0 && $urandom_range(0, 9) < rx_idle_rate) begin
      rx_burst = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]         plane;
    logic [COORD_W-1:0] col, row;
    logic [PIX_W-1:0]   pix;
    logic [DIM_W-1:0]   nw, nh;
    int unsigned        col_span, row_span;
    int                 tx_rate;
    bit                 calm;
    addr_result_t       want;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    rx_idle_rate <= 2;
    @(posedge clk);

    for (int i = 0; i < N_PROBES; i++) begin
      if (probes[i].w != frame_w || probes[i].h != frame_h) begin
        drain_block();
        set_frame(probes[i].w, probes[i].h);
      end
      if (probes[i].typed) begin
        want.linear = probes[i].lin;
        want.tiled = probes[i].til;
        want.pixel = probes[i].pix;
        want.status = probes[i].st;
      end else begin
        want = map_pixel(probes[i].plane, probes[i].col, probes[i].row, probes[i].pix);
      end
      send_word(probes[i].plane, probes[i].col, probes[i].row, probes[i].pix, want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      calm = (p == N_PHASES - 1);
      if (p == 0) begin
        nw = 13'd4096;
        nh = 13'd4096;
      end else if (p == 1) begin
        nw = 13'd512;
        nh = 13'd32;
      end else if ($urandom_range(0, 99) < 85) begin
        nw = DIM_W'(2 * TILE_COLS * $urandom_range(1, 8));
        nh = DIM_W'(2 * TILE_ROWS * $urandom_range(1, 128));
      end else begin
        nw = DIM_W'($urandom_range(0, 8191));
        nh = DIM_W'($urandom_range(0, 8191));
      end
      drain_block();
      set_frame(nw, nh);
      tx_rate = calm ? 0 : $urandom_range(0, 3);
      rx_idle_rate <= calm ? 0 : $urandom_range(0, 3);

      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (tx_rate != 0 && $urandom_range(0, 9) < tx_rate) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        plane = ($urandom_range(0, 9) == 0) ? PLANE_NONE : 2'($urandom_range(0, 2));
        col_span = (plane == PLANE_Y) ? frame_w : frame_w >> 1;
        row_span = (plane == PLANE_Y) ? frame_h : frame_h >> 1;
        if (plane == PLANE_NONE) begin
          col_span = 0;
          row_span = 0;
        end
        if (col_span > 4096) col_span = 4096;
        if (row_span > 4096) row_span = 4096;
        if (col_span != 0 && row_span != 0 && $urandom_range(0, 99) < 85) begin
          col = COORD_W'($urandom_range(0, col_span - 1));
          row = COORD_W'($urandom_range(0, row_span - 1));
        end else begin
          col = COORD_W'($urandom_range(0, 4095));
          row = COORD_W'($urandom_range(0, 4095));
        end
        pix = PIX_W'($urandom_range(0, 255));
        send_word(plane, col, row, pix, map_pixel(plane, col, row, pix));
      end
    end

    drain_block();
    repeat (8) @(posedge clk);
    $display("checked %0d words over %0d frame sizes", mapped_seen + size_seen + range_seen,
             settings_count);
    $display("  mapped %0d, size rejects %0d, outside plane %0d, mismatches %0d",
             mapped_seen, size_seen, range_seen, fail_count);
    if (fail_count == 0 && pending_maps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/i420tl_pkg.sv
src/i420tl_pipe.sv
src/i420_tile_linear_address_map.sv
src/i420tl_checker.sv
bench/testbench.sv
